// ===== rtl/goertzel_tone_magnitude_macros.svh =====
// ---------------------------------------------------------------------------
// goertzel tone magnitude assertion macros
// shared concurrent checks on i_clk with the active-low reset as disable
// ---------------------------------------------------------------------------
`ifndef GOERTZEL_TONE_MAGNITUDE_MACROS_SVH
`define GOERTZEL_TONE_MAGNITUDE_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define GTM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define GTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gtm_pkg.sv =====
// ---------------------------------------------------------------------------
// gtm_pkg
// widths, register indexes, limits and shared types of the tone detector
// ---------------------------------------------------------------------------
package gtm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int REC_W      = 48;
    localparam int ACC_W      = 52;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 19;
    localparam int MUL_P_W    = 51;
    localparam int Q16_SHIFT  = 16;
    localparam int OUT_W      = 18;
    localparam int MAG_W      = 17;
    localparam int CNT_W      = 13;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 19;
    localparam int COS_W      = 18;
    localparam int DIV_W      = ACC_W;
    localparam int DIV_CNT_W  = 6;
    localparam int SQ_W       = 36;
    localparam int ROOT_W     = 19;
    localparam int ROOT_K_W   = 5;
    localparam int ROOT_STEPS = 18;

    localparam logic [CNT_W-1:0] MAX_WINDOW    = CNT_W'(4096);
    localparam logic [CNT_W-1:0] WINDOW_RESET  = CNT_W'(256);
    localparam logic signed [COS_W-1:0] SIN_RESET = COS_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_TWO_COS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COS     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SIN     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = CFG_IDX_W'(3);

    localparam logic signed [MUL_P_W-1:0] Q16_HALF = MUL_P_W'(32768);

    localparam logic signed [ACC_W-1:0] REC_MAX =
        {{(ACC_W-REC_W+1){1'b0}}, {(REC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] REC_MIN =
        {{(ACC_W-REC_W+1){1'b1}}, {(REC_W-1){1'b0}}};

    localparam logic [DIV_W-1:0] OUT_POS_LIM = {{(DIV_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic [DIV_W-1:0] OUT_NEG_LIM = OUT_POS_LIM + DIV_W'(1);
    localparam logic [ROOT_W-1:0] MAG_LIM    = {{(ROOT_W-MAG_W){1'b0}}, {MAG_W{1'b1}}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/gtm_mult.sv =====
// ---------------------------------------------------------------------------
// gtm_mult
// shared signed multiplier with a registered product
// ---------------------------------------------------------------------------
module gtm_mult (
    input  logic                                 i_clk,
    input  logic signed [gtm_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [gtm_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [gtm_pkg::MUL_P_W-1:0]   o_p
);
    import gtm_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/gtm_div.sv =====
// ---------------------------------------------------------------------------
// gtm_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module gtm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gtm_pkg::DIV_W-1:0]     i_dividend,
    input  logic [gtm_pkg::CNT_W-1:0]     i_divisor,
    output gtm_pkg::t_div_stat            o_stat,
    output logic [gtm_pkg::DIV_W-1:0]     o_quotient
);
    import gtm_pkg::*;

    logic [DIV_W-1:0]     r_q;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [CNT_W:0] rem2;
    logic [CNT_W:0] diff;
    logic           ge;

    always_comb begin
        rem2 = {r_rem, r_q[DIV_W-1]};
        diff = rem2 - {1'b0, r_dvs};
        ge   = (rem2 >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= DIV_CNT_W'(DIV_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[DIV_W-2:0], ge};
                r_rem <= ge ? diff[CNT_W-1:0] : rem2[CNT_W-1:0];
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_q;

endmodule

// ===== rtl/goertzel_tone_magnitude.sv =====
// ---------------------------------------------------------------------------
// goertzel_tone_magnitude
// single-tone goertzel detector over windows of N samples, giving I, Q and
// the rounded magnitude once per window
//
//   channel   direction  handshake                    payload
//   cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//   sample    in         i_in_valid / o_in_ready      i_sample
//   result    out        o_out_valid / i_out_ready    o_in_phase, o_quadrature,
//                                                     o_magnitude
//
// a sample goes through the request, the high and low halves through the
// shared multiplier, then add and saturate
// the last sample of a window adds two 52-step divisions by N in the
// bit-serial divider and an 18-step square root
// reset is synchronous, clears the recursion, the count and the output valid flag and presets the config registers
// a finished result waits in the output register; a new window end stalls
// only while that register is still full
// ---------------------------------------------------------------------------
`include "goertzel_tone_magnitude_macros.svh"

module goertzel_tone_magnitude (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gtm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gtm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [gtm_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [gtm_pkg::OUT_W-1:0]      o_in_phase,
    output logic signed [gtm_pkg::OUT_W-1:0]      o_quadrature,
    output logic [gtm_pkg::MAG_W-1:0]             o_magnitude
);
    import gtm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RHI, ST_RLO, ST_RUPD,
        ST_IHI, ST_ILO, ST_IUPD, ST_QHI, ST_QLO, ST_QUPD,
        ST_DIVI, ST_DIVI_W, ST_DIVQ, ST_DIVQ_W,
        ST_SQI, ST_SQQ, ST_SQSUM, ST_ROOT, ST_FIN
    } t_state;

    t_state r_state;

    logic signed [MUL_B_W-1:0]  r_two_cos;
    logic signed [COS_W-1:0]    r_cos;
    logic signed [COS_W-1:0]    r_sin;
    logic [CNT_W-1:0]           r_window;

    logic signed [REC_W-1:0]    r_u1;
    logic signed [REC_W-1:0]    r_u2;
    logic [CNT_W-1:0]           r_count;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [MUL_P_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]    r_ti;
    logic signed [ACC_W-1:0]    r_tq;
    logic signed [OUT_W-1:0]    r_ii;
    logic signed [OUT_W-1:0]    r_qq;
    logic [SQ_W-1:0]            r_rs;
    logic [SQ_W-1:0]            r_rr;
    logic [ROOT_K_W-1:0]        r_k;

    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_in_phase;
    logic signed [OUT_W-1:0]    r_quad;
    logic [MAG_W-1:0]           r_mag;

    // datapath nets
    logic signed [REC_W-1:0]    mul_src;
    logic signed [MUL_B_W-1:0]  mul_coef;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    logic signed [MUL_P_W-1:0]  rnd_sum;
    logic signed [MUL_P_W-1:0]  mq;
    logic signed [ACC_W-1:0]    mq_w;
    logic signed [ACC_W-1:0]    u_sum;
    logic signed [REC_W-1:0]    u_sat;
    logic [CNT_W-1:0]           eff_n;
    logic [CNT_W-1:0]           n_count;
    logic                       win_end;
    logic                       div_start;
    logic [DIV_W-1:0]           div_dividend;
    logic [DIV_W-1:0]           div_quot;
    t_div_stat                  div_stat;
    logic signed [ACC_W-1:0]    div_src;
    logic [SQ_W-1:0]            root_bit;
    logic [SQ_W-1:0]            root_sum;
    logic                       root_ge;
    logic [ROOT_W-1:0]          root_fin;
    logic                       out_load;

    function automatic logic signed [OUT_W-1:0] sat_out(
        input logic [DIV_W-1:0] q,
        input logic             neg
    );
        logic signed [OUT_W-1:0] res;
        if (neg) begin
            res = (q > OUT_NEG_LIM) ? {1'b1, {(OUT_W-1){1'b0}}}
                                    : OUT_W'(0) - q[OUT_W-1:0];
        end else begin
            res = (q > OUT_POS_LIM) ? {1'b0, {(OUT_W-1){1'b1}}} : q[OUT_W-1:0];
        end
        return res;
    endfunction

    // operand selection for the shared multiplier
    always_comb begin
        mul_src  = r_u2;
        mul_coef = MUL_B_W'(r_cos);
        case (r_state)
            ST_RHI, ST_RLO: begin
                mul_src  = r_u1;
                mul_coef = r_two_cos;
            end
            ST_QHI, ST_QLO: begin
                mul_coef = MUL_B_W'(r_sin);
            end
            default: begin
            end
        endcase
        mul_a = mul_src[REC_W-1:REC_W-MUL_A_W];
        mul_b = mul_coef;
        case (r_state)
            ST_RLO, ST_ILO, ST_QLO: begin
                mul_a = {{(MUL_A_W-Q16_SHIFT){1'b0}}, mul_src[Q16_SHIFT-1:0]};
            end
            ST_SQI: begin
                mul_a = MUL_A_W'(r_ii);
                mul_b = MUL_B_W'(r_ii);
            end
            ST_SQQ: begin
                mul_a = MUL_A_W'(r_qq);
                mul_b = MUL_B_W'(r_qq);
            end
            default: begin
            end
        endcase
    end

    gtm_mult u_mult (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // q16 product: high partial in r_acc, low partial rounded on mul_p
    always_comb begin
        rnd_sum = mul_p + Q16_HALF;
        mq      = r_acc + (rnd_sum >>> Q16_SHIFT);
        mq_w    = ACC_W'(mq);
        u_sum   = mq_w - ACC_W'(r_u2) + ACC_W'(r_x);
        if (u_sum > REC_MAX) begin
            u_sat = REC_MAX[REC_W-1:0];
        end else if (u_sum < REC_MIN) begin
            u_sat = REC_MIN[REC_W-1:0];
        end else begin
            u_sat = u_sum[REC_W-1:0];
        end
    end

    always_comb begin
        if (r_window == '0) begin
            eff_n = CNT_W'(1);
        end else if (r_window > MAX_WINDOW) begin
            eff_n = MAX_WINDOW;
        end else begin
            eff_n = r_window;
        end
        n_count = r_count + CNT_W'(1);
        win_end = (n_count >= eff_n);
    end

    // rounded division by N of the absolute I and Q terms
    always_comb begin
        div_start = (r_state == ST_DIVI) || (r_state == ST_DIVQ);
        div_src   = (r_state == ST_DIVQ) ? r_tq : r_ti;
        div_dividend = (div_src[ACC_W-1] ? DIV_W'(-div_src) : DIV_W'(div_src))
                     + DIV_W'(eff_n >> 1);
    end

    gtm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (eff_n),
        .o_stat     (div_stat),
        .o_quotient (div_quot)
    );

    // square root, one result bit per step from two radicand bits
    always_comb begin
        root_bit = SQ_W'(1) << {r_k, 1'b0};
        root_sum = r_rr + root_bit;
        root_ge  = (r_rs >= root_sum);
        root_fin = r_rr[ROOT_W-1:0] + ROOT_W'(r_rs > r_rr);
        out_load = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_two_cos   <= '0;
            r_cos       <= '0;
            r_sin       <= SIN_RESET;
            r_window    <= WINDOW_RESET;
            r_u1        <= '0;
            r_u2        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TWO_COS: r_two_cos <= i_cfg_data[MUL_B_W-1:0];
                    REG_COS:     r_cos     <= i_cfg_data[COS_W-1:0];
                    REG_SIN:     r_sin     <= i_cfg_data[COS_W-1:0];
                    REG_WINDOW:  r_window  <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_sample;
                        r_state <= ST_RHI;
                    end
                end
                ST_RHI: r_state <= ST_RLO;
                ST_RLO: begin
                    r_acc   <= mul_p;
                    r_state <= ST_RUPD;
                end
                ST_RUPD: begin
                    r_u2    <= r_u1;
                    r_u1    <= u_sat;
                    r_count <= n_count;
                    r_state <= win_end ? ST_IHI : ST_IDLE;
                end
                ST_IHI: r_state <= ST_ILO;
                ST_ILO: begin
                    r_acc   <= mul_p;
                    r_state <= ST_IUPD;
                end
                ST_IUPD: begin
                    r_ti    <= (ACC_W'(r_u1) - mq_w) <<< 1;
                    r_state <= ST_QHI;
                end
                ST_QHI: r_state <= ST_QLO;
                ST_QLO: begin
                    r_acc   <= mul_p;
                    r_state <= ST_QUPD;
                end
                ST_QUPD: begin
                    r_tq    <= mq_w <<< 1;
                    r_state <= ST_DIVI;
                end
                ST_DIVI: r_state <= ST_DIVI_W;
                ST_DIVI_W: begin
                    if (div_stat.done) begin
                        r_ii    <= sat_out(div_quot, r_ti[ACC_W-1]);
                        r_state <= ST_DIVQ;
                    end
                end
                ST_DIVQ: r_state <= ST_DIVQ_W;
                ST_DIVQ_W: begin
                    if (div_stat.done) begin
                        r_qq    <= sat_out(div_quot, r_tq[ACC_W-1]);
                        r_state <= ST_SQI;
                    end
                end
                ST_SQI: r_state <= ST_SQQ;
                ST_SQQ: begin
                    r_acc   <= mul_p;
                    r_state <= ST_SQSUM;
                end
                ST_SQSUM: begin
                    r_rs    <= r_acc[SQ_W-1:0] + mul_p[SQ_W-1:0];
                    r_rr    <= '0;
                    r_k     <= ROOT_K_W'(ROOT_STEPS - 1);
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (root_ge) begin
                        r_rs <= r_rs - root_sum;
                        r_rr <= (r_rr >> 1) + root_bit;
                    end else begin
                        r_rr <= r_rr >> 1;
                    end
                    r_k <= r_k - ROOT_K_W'(1);
                    if (r_k == '0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_load) begin
                        r_in_phase  <= r_ii;
                        r_quad      <= r_qq;
                        r_mag       <= (root_fin > MAG_LIM) ? MAG_LIM[MAG_W-1:0]
                                                            : root_fin[MAG_W-1:0];
                        r_out_valid <= 1'b1;
                        r_u1        <= '0;
                        r_u2        <= '0;
                        r_count     <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_in_phase   = r_in_phase;
    assign o_quadrature = r_quad;
    assign o_magnitude  = r_mag;

    `GTM_ASSERT_SAME(a_count_bound, 1'b1, r_count <= MAX_WINDOW, "sample count beyond window limit")
    `GTM_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
    `GTM_ASSERT_NEXT(a_window_cleared, out_load, (r_count == '0) && (r_u1 == '0) && (r_u2 == '0) && o_out_valid, "window not cleared after result")

endmodule
